// File: rtl/core/sgd_pkg.sv
// Package for the signed Golomb bit decoder.
// Holds the field widths, the phase encoding and the remainder width function.
// No dependencies; every other file of the block but sgd_in_if imports it.
package sgd_pkg;

    localparam int DIVISOR_BITS  = 12;
    localparam int QUOTIENT_BITS = 12;
    localparam int MAG_W         = 24;
    localparam int VALUE_W       = MAG_W + 1;
    localparam int REM_CNT_W     = $clog2(DIVISOR_BITS + 1);
    localparam int SUM_W         = QUOTIENT_BITS + DIVISOR_BITS + 1;
    localparam int CMP_W         = (SUM_W > MAG_W) ? SUM_W : MAG_W + 1;

    localparam logic [DIVISOR_BITS-1:0]  DIVISOR_RESET = DIVISOR_BITS'(4);
    localparam logic [QUOTIENT_BITS-1:0] QUOT_MAX      = '1;
    localparam logic [MAG_W-1:0]         MAG_MAX       = '1;

    typedef enum logic [2:0] {
        PH_SIGN  = 3'b001,
        PH_UNARY = 3'b010,
        PH_REM   = 3'b100
    } t_phase;

    // Remainder width: the number of powers of two below the divisor, which is
    // ceil(log2(m)) for m above one and zero for m of zero or one.
    function automatic logic [REM_CNT_W-1:0] rem_width(input logic [DIVISOR_BITS-1:0] m);
        logic [REM_CNT_W-1:0]  cnt;
        logic [DIVISOR_BITS:0] pow;
        cnt = '0;
        for (int i = 0; i < DIVISOR_BITS; i++) begin
            pow = (DIVISOR_BITS+1)'(1) << i;
            if ({1'b0, m} > pow) begin
                cnt = cnt + REM_CNT_W'(1);
            end
        end
        return cnt;
    endfunction

endpackage

// File: rtl/core/sgd_in_if.sv
// Input channel of the signed Golomb bit decoder: one code bit per transfer.
// Uses nothing from sgd_pkg.
interface sgd_in_if;
    logic valid;
    logic ready;
    logic bit_in;

    modport source (output valid, output bit_in, input ready);
    modport sink (input valid, input bit_in, output ready);
endinterface

// File: rtl/core/sgd_out_if.sv
// Output channel of the signed Golomb bit decoder: one decoded value per transfer.
// Depends on sgd_pkg for the value width.
interface sgd_out_if;
    import sgd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;

    modport source (output valid, output value, output overflow, input ready);
    modport sink (input valid, input value, input overflow, output ready);
endinterface

// File: rtl/core/signed_golomb_bit_decoder.sv
// Top level of the signed Golomb bit decoder.
// Depends on sgd_pkg, sgd_in_if and sgd_out_if.
//
// Usage: code bits arrive one per transfer on i_in (valid/ready). Each codeword
// is a sign bit, a unary quotient of ones closed by a zero, and a remainder of
// ceil(log2(divisor)) bits, MSB first. When the last bit of a codeword is taken,
// the decoded value and its overflow flag pass through the pipeline to o_out.
// The divisor is written through i_cfg_we and i_cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. It resets to 4.
// Throughput is one code bit per cycle while i_in.ready is high: the bit decoder
// then takes a bit each cycle, and a three-register pipeline (codeword capture,
// multiply-add, sign and clamp) forms the result, so codewords may follow each
// other back to back. When the receiver stalls, the pipeline keeps taking bits until
// its stages holding finished codewords are full; only then does i_in.ready drop.
// Reset is synchronous and active low; it empties the pipeline, returns the
// decoder to expect a sign bit and loads the divisor reset value.
module signed_golomb_bit_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sgd_in_if.sink                          i_in,
    sgd_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [sgd_pkg::DIVISOR_BITS-1:0] i_cfg_wdata
);
    import sgd_pkg::*;

    logic [DIVISOR_BITS-1:0]  r_divisor;

    t_phase                   r_phase, n_phase;
    logic                     r_sign, n_sign;
    logic [QUOTIENT_BITS-1:0] r_quot, n_quot;
    logic [DIVISOR_BITS-1:0]  r_rem, n_rem;
    logic [REM_CNT_W-1:0]     r_bits_left, n_bits_left;
    logic                     r_sat, n_sat;
    logic                     emit;

    logic                     r_a_v;
    logic [QUOTIENT_BITS-1:0] r_a_q;
    logic [DIVISOR_BITS-1:0]  r_a_d;
    logic [DIVISOR_BITS-1:0]  r_a_r;
    logic                     r_a_sign;
    logic                     r_a_sat;

    logic                     r_b_v;
    logic [SUM_W-1:0]         r_b_mag;
    logic                     r_b_sign;
    logic                     r_b_ovf;

    logic                     r_c_v;
    logic [VALUE_W-1:0]       r_c_value;
    logic                     r_c_ovf;

    logic                     c_take, b_take, a_take, accept;
    logic [SUM_W-1:0]         sum;
    logic [CMP_W-1:0]         mag_wide;
    logic [MAG_W-1:0]         mag;
    logic                     clamp;
    logic [VALUE_W-1:0]       mag_ext;

    assign c_take = !r_c_v || o_out.ready;
    assign b_take = !r_b_v || c_take;
    assign a_take = !r_a_v || b_take;
    assign accept = i_in.valid && a_take;
    assign i_in.ready = a_take;

    always_comb begin
        n_phase     = r_phase;
        n_sign      = r_sign;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_bits_left = r_bits_left;
        n_sat       = r_sat;
        emit        = 1'b0;
        unique case (r_phase)
            PH_UNARY: begin
                if (i_in.bit_in) begin
                    if (r_quot == QUOT_MAX) begin
                        n_sat = 1'b1;
                    end else begin
                        n_quot = r_quot + QUOTIENT_BITS'(1);
                    end
                end else begin
                    n_bits_left = rem_width(r_divisor);
                    n_rem       = '0;
                    if (n_bits_left == '0) begin
                        emit    = 1'b1;
                        n_phase = PH_SIGN;
                    end else begin
                        n_phase = PH_REM;
                    end
                end
            end
            PH_REM: begin
                n_rem       = {r_rem[DIVISOR_BITS-2:0], i_in.bit_in};
                n_bits_left = r_bits_left - REM_CNT_W'(1);
                if (n_bits_left == '0) begin
                    emit    = 1'b1;
                    n_phase = PH_SIGN;
                end
            end
            default: begin
                n_sign      = i_in.bit_in;
                n_quot      = '0;
                n_rem       = '0;
                n_bits_left = '0;
                n_sat       = 1'b0;
                n_phase     = PH_UNARY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= DIVISOR_RESET;
        end else if (i_cfg_we) begin
            r_divisor <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIGN;
            r_sign      <= 1'b0;
            r_quot      <= '0;
            r_rem       <= '0;
            r_bits_left <= '0;
            r_sat       <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_sign      <= n_sign;
            r_quot      <= n_quot;
            r_rem       <= n_rem;
            r_bits_left <= n_bits_left;
            r_sat       <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_take) begin
            r_a_v <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take && accept && emit) begin
            r_a_q    <= r_quot;
            r_a_d    <= r_divisor;
            r_a_r    <= n_rem;
            r_a_sign <= r_sign;
            r_a_sat  <= r_sat;
        end
    end

    always_comb begin
        sum = SUM_W'(r_a_q) * SUM_W'(r_a_d) + SUM_W'(r_a_r);
        if (r_a_d == '0) begin
            sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_take) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_take && r_a_v) begin
            r_b_mag  <= sum;
            r_b_sign <= r_a_sign;
            r_b_ovf  <= r_a_sat;
        end
    end

    assign mag_wide = CMP_W'(r_b_mag);
    assign clamp    = mag_wide > CMP_W'(MAG_MAX);
    assign mag      = clamp ? MAG_MAX : MAG_W'(mag_wide);
    assign mag_ext  = {1'b0, mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (c_take) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take && r_b_v) begin
            r_c_value <= (r_b_sign && mag != '0) ? (~mag_ext + VALUE_W'(1)) : mag_ext;
            r_c_ovf   <= r_b_ovf || clamp;
        end
    end

    assign o_out.valid    = r_c_v;
    assign o_out.value    = r_c_value;
    assign o_out.overflow = r_c_ovf;

    // The input stalls only when the output stage holds a result.
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no result waiting");

    // The remainder phase always has bits still to come.
    a_rem_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_REM |-> r_bits_left != '0)
        else $error("remainder phase with no bits left");

    // Saturation is only flagged once the quotient counter sits at its maximum.
    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UNARY && r_sat) |-> r_quot == QUOT_MAX)
        else $error("saturation flagged below the quotient maximum");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the signed Golomb bit decoder: directed and random code bit streams.
// Results are predicted by a scoreboard class and compared field by field on every transfer.
// Depends on sgd_pkg, sgd_in_if, sgd_out_if and signed_golomb_bit_decoder.
module testbench;
    import sgd_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      overflow;
    } t_decoded;

    class golomb_scoreboard;
        logic [DIVISOR_BITS-1:0]  divisor;
        t_phase                   ph;
        logic                     sgn;
        logic [QUOTIENT_BITS-1:0] quot;
        logic [15:0]              rem_acc;
        int unsigned              bits_left;
        logic                     sat;
        t_decoded                 pending_q[$];
        int                       errors;

        function new();
            divisor = DIVISOR_RESET;
            errors  = 0;
            clear_word();
        endfunction

        function void clear_word();
            ph        = PH_SIGN;
            sgn       = 1'b0;
            quot      = '0;
            rem_acc   = '0;
            bits_left = 0;
            sat       = 1'b0;
        endfunction

        function int unsigned code_width(logic [DIVISOR_BITS-1:0] m);
            int unsigned b;
            b = 0;
            while (b < DIVISOR_BITS && (32'd1 << b) < m) b++;
            return b;
        endfunction

        function void push_word();
            logic [31:0] mag;
            logic [31:0] neg;
            t_decoded    d;
            mag        = 32'(quot) * 32'(divisor) + 32'(rem_acc);
            d.overflow = sat;
            if (divisor == '0) mag = '0;
            if (mag > 32'(MAG_MAX)) begin
                mag        = 32'(MAG_MAX);
                d.overflow = 1'b1;
            end
            neg     = 32'd0 - mag;
            d.value = (sgn && mag != 0) ? neg[VALUE_W-1:0] : mag[VALUE_W-1:0];
            pending_q.insert(pending_q.size(), d);
            clear_word();
        endfunction

        function void note_bit(logic b);
            case (ph)
                PH_UNARY: begin
                    if (b) begin
                        if (quot == QUOT_MAX) sat = 1'b1;
                        else quot = quot + 1'b1;
                    end else begin
                        bits_left = code_width(divisor);
                        rem_acc   = '0;
                        if (bits_left == 0) push_word();
                        else ph = PH_REM;
                    end
                end
                PH_REM: begin
                    rem_acc = {rem_acc[14:0], b};
                    if (bits_left > 0) bits_left--;
                    if (bits_left == 0) push_word();
                end
                default: begin
                    clear_word();
                    sgn = b;
                    ph  = PH_UNARY;
                end
            endcase
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] value, logic overflow);
            t_decoded d;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result value %0d overflow %0b", value, overflow));
                return;
            end
            d = pending_q.pop_front();
            if (value !== d.value || overflow !== d.overflow)
                report($sformatf("value expected %0d got %0d, overflow expected %0b got %0b",
                                 d.value, value, d.overflow, overflow));
        endfunction

        function void close();
            if (pending_q.size() != 0)
                report($sformatf("%0d expected results never arrived", pending_q.size()));
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we;
    logic [DIVISOR_BITS-1:0] i_cfg_wdata;

    sgd_in_if  in_if ();
    sgd_out_if out_if ();

    signed_golomb_bit_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    golomb_scoreboard sb = new();

    int burst_left = 0;
    bit no_gaps = 1'b0;
    int bits_sent = 0;
    int holdoff_asked = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver changes its stall pattern in stretches and honors hold-off requests.
    initial begin
        int stretch;
        int mode;
        int hold_left;
        int holds_seen;
        stretch    = 0;
        mode       = 0;
        hold_left  = 0;
        holds_seen = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
                sb.check_result(out_if.value, out_if.overflow);
            if (holds_seen != holdoff_asked) begin
                holds_seen = holdoff_asked;
                hold_left  = 300;
            end
            if (stretch == 0) begin
                mode    = $urandom_range(0, 2);
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    task automatic put_bit(input logic b);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (!no_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_if.valid  <= 1'b1;
        in_if.bit_in <= b;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_bit(b);
        bits_sent++;
    endtask

    task automatic send_codeword(input logic sgn, input int quot, input logic [11:0] rem);
        int b;
        b = sb.code_width(sb.divisor);
        put_bit(sgn);
        repeat (quot) put_bit(1'b1);
        put_bit(1'b0);
        for (int i = b - 1; i >= 0; i--) put_bit(rem[i]);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_divisor(input logic [DIVISOR_BITS-1:0] d);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.divisor = d;
    endtask

    function automatic logic [DIVISOR_BITS-1:0] pick_divisor();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'd1;
            2: return 12'd2;
            3: return 12'd3;
            4: return 12'd4095;
            5: return 12'd2048;
            6: return 12'd2049;
            7: return 12'd4;
            8: return 12'($urandom_range(1, 16));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic int pick_quotient();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return $urandom_range(0, 6);
        if (sel < 19) return $urandom_range(0, 40);
        return $urandom_range(41, 150);
    endfunction

    initial begin
        int phase_start;
        int target;
        in_if.valid  = 1'b0;
        in_if.bit_in = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset divisor of four: a negative zero and a full remainder.
        send_codeword(1'b1, 0, 12'd0);
        send_codeword(1'b0, 3, 12'd3);

        // Divisor changed inside the unary part and again inside the remainder.
        write_divisor(12'd2);
        put_bit(1'b1);
        put_bit(1'b1);
        put_bit(1'b1);
        write_divisor(12'd8);
        put_bit(1'b0);
        put_bit(1'b1);
        put_bit(1'b0);
        put_bit(1'b1);
        put_bit(1'b0);
        put_bit(1'b1);
        put_bit(1'b0);
        put_bit(1'b1);
        write_divisor(12'd2);
        put_bit(1'b1);
        put_bit(1'b0);

        // The receiver holds off while short codewords keep arriving back to back.
        write_divisor(12'd1);
        holdoff_asked++;
        no_gaps = 1'b1;
        repeat (60) send_codeword(1'($urandom_range(0, 1)), $urandom_range(0, 3), 12'd0);
        no_gaps = 1'b0;

        while (bits_sent < 1450) begin
            write_divisor(pick_divisor());
            no_gaps     = ($urandom_range(0, 4) == 0);
            phase_start = bits_sent;
            target      = $urandom_range(60, 180);
            while (bits_sent - phase_start < target && bits_sent < 1450) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 8)) put_bit(1'($urandom_range(0, 1)));
                end else begin
                    send_codeword(1'($urandom_range(0, 1)), pick_quotient(),
                                  12'($urandom_range(0, 4095)));
                end
            end
        end
        no_gaps = 1'b0;

        wait_idle();
        repeat (10) @(posedge i_clk);
        sb.close();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
